### hw/rtl/afcc_pkg.sv
package afcc_pkg;

    localparam logic [1:0] OP_COMPOSITE = 2'd0;
    localparam logic [1:0] OP_CLEAR     = 2'd1;
    localparam logic [1:0] OP_READ      = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

    // Work kinds that the front end hands to the back end.
    localparam logic [1:0] KIND_SKIP  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_BLEND = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

endpackage

### hw/rtl/afcc_ram.sv
module afcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### hw/rtl/afcc_div.sv
module afcc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [16:0] dividend,
    input  logic [8:0]  divisor,
    output logic        done,
    output logic [16:0] quotient
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] q_reg, q_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  dsr_reg, dsr_next;
    logic [9:0]  trial;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done      = 1'b0;
        trial     = {rem_reg, q_reg[16]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            q_next    = dividend;
            rem_next  = 9'd0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = 9'(trial - {1'b0, dsr_reg});
                q_next   = {q_reg[15:0], 1'b1};
            end else begin
                rem_next = trial[8:0];
                q_next   = {q_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd16) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = q_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end
endmodule

### hw/rtl/afcc_front.sv
module afcc_front #(
    parameter int MAX_CANVAS_WIDTH  = 256,
    parameter int MAX_CANVAS_HEIGHT = 256,
    parameter int AW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [8:0]           cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    input  logic [7:0]           s_frame_x_offset,
    input  logic [7:0]           s_frame_y_offset,
    input  logic [7:0]           s_pixel_x,
    input  logic [7:0]           s_pixel_y,
    input  afcc_pkg::pixel_t     s_src,
    input  logic                 s_blend_enable,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [1:0]           q_kind,
    output logic [AW-1:0]        q_addr,
    output afcc_pkg::pixel_t     q_src
);
    import afcc_pkg::*;

    localparam int WW = $clog2(MAX_CANVAS_WIDTH + 1);
    localparam int HW = $clog2(MAX_CANVAS_HEIGHT + 1);
    localparam int PW = (WW > HW ? WW : HW) + 10;

    logic [8:0] width_reg, height_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [9:0] cx, cy;
    logic on_canvas;
    logic [PW-1:0] row, col;
    logic [1:0] kind;
    logic       st_valid_reg;
    logic [1:0] st_kind_reg;
    logic [PW-1:0] st_row_reg, st_col_reg;
    logic [WW-1:0] st_w_reg;
    pixel_t st_src_reg;
    logic [2*PW-1:0] addr_full;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_WIDTH) width_reg <= cfg_data;
            if (cfg_index == REG_HEIGHT) height_reg <= cfg_data;
        end
    end

    // Saturate the dimensions into their legal range.
    always_comb begin
        if (width_reg == 9'd0) w_eff = WW'(1);
        else if (32'(width_reg) > MAX_CANVAS_WIDTH) w_eff = WW'(MAX_CANVAS_WIDTH);
        else w_eff = WW'(width_reg);
        if (height_reg == 9'd0) h_eff = HW'(1);
        else if (32'(height_reg) > MAX_CANVAS_HEIGHT) h_eff = HW'(MAX_CANVAS_HEIGHT);
        else h_eff = HW'(height_reg);
    end

    // Clip, flip and classify the request.
    always_comb begin
        cx = 10'(s_frame_x_offset) + 10'(s_pixel_x);
        cy = 10'(s_frame_y_offset) + 10'(s_pixel_y);
        on_canvas = 1'b0;
        row = '0;
        col = '0;
        kind = KIND_SKIP;
        if (s_operation == OP_COMPOSITE || s_operation == OP_CLEAR) begin
            on_canvas = (PW'(cx) < PW'(w_eff)) && (PW'(cy) < PW'(h_eff));
            row = PW'(h_eff) - PW'(1) - PW'(cy);
            col = PW'(cx);
            if (s_operation == OP_CLEAR) kind = KIND_WRITE;
            else if (!s_blend_enable || s_src.a == 8'd255) kind = KIND_WRITE;
            else if (s_src.a == 8'd0) kind = KIND_READ;
            else kind = KIND_BLEND;
        end else if (s_operation == OP_READ) begin
            on_canvas = (PW'(s_pixel_x) < PW'(w_eff)) && (PW'(s_pixel_y) < PW'(h_eff));
            row = PW'(s_pixel_y);
            col = PW'(s_pixel_x);
            kind = KIND_READ;
        end
        if (!on_canvas) kind = KIND_SKIP;
    end

    assign s_ready = !st_valid_reg || q_ready;

    // Stage register; the address multiply follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            st_kind_reg <= kind;
            st_row_reg  <= row;
            st_col_reg  <= col;
            st_w_reg    <= w_eff;
            st_src_reg  <= (s_operation == OP_CLEAR) ? '0 : s_src;
        end
    end

    assign addr_full = st_row_reg * (2*PW)'(st_w_reg) + (2*PW)'(st_col_reg);
    assign q_valid = st_valid_reg;
    assign q_kind  = st_kind_reg;
    assign q_addr  = AW'(addr_full);
    assign q_src   = st_src_reg;
endmodule

### hw/rtl/afcc_back.sv
module afcc_back #(
    parameter int AW = 16,
    parameter int DEPTH = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [1:0]           q_kind,
    input  logic [AW-1:0]        q_addr,
    input  afcc_pkg::pixel_t     q_src,
    output logic                 m_valid,
    input  logic                 m_ready,
    output afcc_pkg::pixel_t     m_pix,
    output logic                 m_in_canvas
);
    import afcc_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_MUL2  = 4'd4;
    localparam logic [3:0] ST_SCALE = 4'd5;
    localparam logic [3:0] ST_START = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_WR    = 4'd8;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    // 2^32/255 rounded up; exact floor division by 255 for products up to 255^3.
    localparam logic [24:0] RECIP_255 = 25'h1010102;

    logic [3:0] state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0] kind_reg, kind_next;
    logic [AW-1:0] addr_reg, addr_next;
    pixel_t src_reg, src_next, dst_reg, dst_next, res_reg, res_next;
    logic [1:0] ch_reg, ch_next;
    logic [7:0] oa_reg, oa_next;
    logic [23:0] prod_reg, prod_next;
    logic [15:0] part_reg, part_next;
    logic out_valid_reg, out_valid_next;
    pixel_t out_pix_reg, out_pix_next;
    logic out_in_reg, out_in_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0] wr_data, rd_data;
    logic div_start;
    logic [16:0] div_n;
    logic [8:0] div_d;
    logic div_done;
    logic [16:0] div_q;
    logic [7:0] inv, da, sc, dc;
    logic [7:0] cres;
    logic [48:0] scaled;
    logic [15:0] quot255;
    logic [7:0] oa_sum;

    afcc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    afcc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_n),
        .divisor(div_d), .done(div_done), .quotient(div_q)
    );

    assign inv = 8'd255 - src_reg.a;
    assign da  = dst_reg.a;
    assign rd_addr = q_addr;
    assign q_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign cres = (div_q > 17'd255) ? 8'd255 : div_q[7:0];

    // Truncating division of the registered product by 255.
    assign scaled  = 49'(prod_reg) * 49'(RECIP_255);
    assign quot255 = scaled[47:32];
    assign oa_sum  = src_reg.a + quot255[7:0];

    // Color numerator s*sa + d*da*inv/255, divided by the output alpha.
    assign div_n = 17'(sc) * 17'(src_reg.a) + 17'(part_reg);
    assign div_d = {1'b0, oa_reg};

    always_comb begin
        case (ch_reg)
            CH_RED:   begin sc = src_reg.r; dc = dst_reg.r; end
            CH_GREEN: begin sc = src_reg.g; dc = dst_reg.g; end
            default:  begin sc = src_reg.b; dc = dst_reg.b; end
        endcase
    end

    // Sequencer: clear sweep, then per request a skip, a read, a write or a read-modify-write blend.
    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        kind_next = kind_reg;
        addr_next = addr_reg;
        src_next = src_reg;
        dst_next = dst_reg;
        res_next = res_reg;
        ch_next = ch_reg;
        oa_next = oa_reg;
        prod_next = prod_reg;
        part_next = part_reg;
        out_valid_next = out_valid_reg;
        out_pix_next = out_pix_reg;
        out_in_next = out_in_reg;
        wr_en = 1'b0;
        wr_addr = addr_reg;
        wr_data = res_reg;
        div_start = 1'b0;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid && q_ready) begin
                    kind_next = q_kind;
                    addr_next = q_addr;
                    src_next = q_src;
                    if (q_kind == KIND_SKIP) begin
                        out_valid_next = 1'b1;
                        out_pix_next = '0;
                        out_in_next = 1'b0;
                    end else if (q_kind == KIND_WRITE) begin
                        res_next = q_src;
                        state_next = ST_WR;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                dst_next = rd_data;
                res_next = rd_data;
                if (kind_reg == KIND_BLEND) begin
                    ch_next = CH_ALPHA;
                    state_next = ST_MUL;
                end else begin
                    // Read, or a transparent blend that leaves the pixel as it is.
                    out_valid_next = 1'b1;
                    out_pix_next = rd_data;
                    out_in_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                // The alpha pass forms da*inv; a color pass starts d*da.
                if (ch_reg == CH_ALPHA) begin
                    prod_next = 24'(da) * 24'(inv);
                    state_next = ST_SCALE;
                end else begin
                    prod_next = 24'(dc) * 24'(da);
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                prod_next = prod_reg * 24'(inv);
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                if (ch_reg == CH_ALPHA) begin
                    oa_next = oa_sum;
                    res_next.a = oa_sum;
                    ch_next = CH_RED;
                    state_next = ST_MUL;
                end else begin
                    part_next = quot255;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    case (ch_reg)
                        CH_RED:   res_next.r = cres;
                        CH_GREEN: res_next.g = cres;
                        default:  res_next.b = cres;
                    endcase
                    if (ch_reg == CH_BLUE) begin
                        state_next = ST_WR;
                    end else begin
                        ch_next = ch_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_WR: begin
                wr_en = 1'b1;
                out_valid_next = 1'b1;
                out_pix_next = res_reg;
                out_in_next = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        src_reg <= src_next;
        dst_reg <= dst_next;
        res_reg <= res_next;
        ch_reg <= ch_next;
        oa_reg <= oa_next;
        prod_reg <= prod_next;
        part_reg <= part_next;
        out_pix_reg <= out_pix_next;
        out_in_reg <= out_in_next;
    end

    assign m_valid = out_valid_reg;
    assign m_pix = out_pix_reg;
    assign m_in_canvas = out_in_reg;
endmodule

### hw/rtl/animated_frame_canvas_compositor.sv
// A skipped pixel goes straight to the output register, a copy, clear or read makes
// one memory access, and a blend reads the pixel, runs the bit-serial divider once for
// each of the three colors and writes the result back. The back end holds one request
// until its result is taken and takes no new one before that; the front end holds one
// more. Reset: synchronous active-low aresetn, then the back end clears all
// MAX_CANVAS_WIDTH*MAX_CANVAS_HEIGHT memory words before it takes a request.
module animated_frame_canvas_compositor #(
    parameter int MAX_CANVAS_WIDTH  = 256,
    parameter int MAX_CANVAS_HEIGHT = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_frame_x_offset,
    input  logic [7:0] s_frame_y_offset,
    input  logic [7:0] s_pixel_x,
    input  logic [7:0] s_pixel_y,
    input  logic [7:0] s_src_red,
    input  logic [7:0] s_src_green,
    input  logic [7:0] s_src_blue,
    input  logic [7:0] s_src_alpha,
    input  logic       s_blend_enable,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_red,
    output logic [7:0] m_out_green,
    output logic [7:0] m_out_blue,
    output logic [7:0] m_out_alpha,
    output logic       m_in_canvas
);
    import afcc_pkg::*;

    localparam int DEPTH = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic q_valid, q_ready;
    logic [1:0] q_kind;
    logic [AW-1:0] q_addr;
    pixel_t q_src, s_src, m_pix;

    assign s_src = '{r: s_src_red, g: s_src_green, b: s_src_blue, a: s_src_alpha};

    afcc_front #(.MAX_CANVAS_WIDTH(MAX_CANVAS_WIDTH),
                 .MAX_CANVAS_HEIGHT(MAX_CANVAS_HEIGHT), .AW(AW)) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(s_operation), .s_frame_x_offset(s_frame_x_offset),
        .s_frame_y_offset(s_frame_y_offset), .s_pixel_x(s_pixel_x),
        .s_pixel_y(s_pixel_y), .s_src(s_src), .s_blend_enable(s_blend_enable),
        .q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind), .q_addr(q_addr),
        .q_src(q_src)
    );

    afcc_back #(.AW(AW), .DEPTH(DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_addr(q_addr), .q_src(q_src), .m_valid(m_valid),
        .m_ready(m_ready), .m_pix(m_pix), .m_in_canvas(m_in_canvas)
    );

    assign m_out_red   = m_pix.r;
    assign m_out_green = m_pix.g;
    assign m_out_blue  = m_pix.b;
    assign m_out_alpha = m_pix.a;
endmodule

### tb/tb_canvas_checker.sv
module tb_canvas_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [7:0] s_frame_x_offset,
    input  logic [7:0] s_frame_y_offset,
    input  logic [7:0] s_pixel_x,
    input  logic [7:0] s_pixel_y,
    input  logic [7:0] s_src_red,
    input  logic [7:0] s_src_green,
    input  logic [7:0] s_src_blue,
    input  logic [7:0] s_src_alpha,
    input  logic       s_blend_enable,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_red,
    input  logic [7:0] m_out_green,
    input  logic [7:0] m_out_blue,
    input  logic [7:0] m_out_alpha,
    input  logic       m_in_canvas,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import afcc_pkg::*;

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       on_canvas;
    } canvas_result_t;

    logic [31:0]    shadow_canvas [0:65535];
    logic [8:0]     shadow_width;
    logic [8:0]     shadow_height;
    canvas_result_t expected_pixels [EXP_DEPTH];
    int             exp_wr;
    int             exp_rd;

    assign pending_count = exp_wr - exp_rd;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int clamp_dim(input logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    // Source-over blend with truncating divisions; alpha in bits 31..24.
    function automatic logic [31:0] blend_source_over(input logic [31:0] dst,
                                                      input logic [31:0] src);
        int sa, da, inv, oa, num, c;
        logic [31:0] res;
        sa  = src[31:24];
        da  = dst[31:24];
        inv = 255 - sa;
        oa  = sa + (da * inv) / 255;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            num = src[8*k +: 8] * sa + (dst[8*k +: 8] * da * inv) / 255;
            c   = num / oa;
            res[8*k +: 8] = (c > 255) ? 8'd255 : c[7:0];
        end
        res[31:24] = oa[7:0];
        return res;
    endfunction

    // Apply one request to the shadow canvas and return its result.
    function automatic canvas_result_t apply_request();
        int w, h, col, cy, addr;
        logic [31:0] word, src;
        canvas_result_t res;
        w    = clamp_dim(shadow_width);
        h    = clamp_dim(shadow_height);
        word = '0;
        res  = '0;
        src  = {s_src_alpha, s_src_blue, s_src_green, s_src_red};
        if (s_operation == OP_COMPOSITE || s_operation == OP_CLEAR) begin
            col = s_frame_x_offset + s_pixel_x;
            cy  = s_frame_y_offset + s_pixel_y;
            if (col < w && cy < h) begin
                res.on_canvas = 1'b1;
                addr = (h - 1 - cy) * w + col;
                word = shadow_canvas[addr];
                if (s_operation == OP_CLEAR) begin
                    word = '0;
                end else if (!s_blend_enable || s_src_alpha == 8'd255) begin
                    word = src;
                end else if (s_src_alpha != 8'd0) begin
                    word = blend_source_over(word, src);
                end
                shadow_canvas[addr] = word;
            end
        end else if (s_operation == OP_READ) begin
            if (s_pixel_x < w && s_pixel_y < h) begin
                res.on_canvas = 1'b1;
                word = shadow_canvas[s_pixel_y * w + s_pixel_x];
            end
        end
        if (!res.on_canvas) word = '0;
        res.r = word[7:0];
        res.g = word[15:8];
        res.b = word[23:16];
        res.a = word[31:24];
        return res;
    endfunction

    // Compare results, predict on accepted requests, then track configuration.
    always @(posedge aclk) begin
        canvas_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < 65536; i++) shadow_canvas[i] = '0;
            shadow_width  = 9'd256;
            shadow_height = 9'd256;
            exp_wr = 0;
            exp_rd = 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (exp_wr == exp_rd) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_pixels[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (m_out_red !== want.r) report_mismatch("red", m_out_red, want.r);
                    if (m_out_green !== want.g)
                        report_mismatch("green", m_out_green, want.g);
                    if (m_out_blue !== want.b) report_mismatch("blue", m_out_blue, want.b);
                    if (m_out_alpha !== want.a)
                        report_mismatch("alpha", m_out_alpha, want.a);
                    if (m_in_canvas !== want.on_canvas)
                        report_mismatch("in_canvas", m_in_canvas, want.on_canvas);
                end
            end
            if (s_valid && s_ready) begin
                if (exp_wr - exp_rd >= EXP_DEPTH) begin
                    report_mismatch("requests in flight", exp_wr - exp_rd, EXP_DEPTH - 1);
                end else begin
                    expected_pixels[exp_wr % EXP_DEPTH] = apply_request();
                    exp_wr++;
                end
            end
            if (cfg_wr_en) begin
                if (cfg_index == REG_WIDTH) shadow_width = cfg_data;
                else shadow_height = cfg_data;
            end
        end
    end
endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import afcc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_index = 1'b0;
    logic [8:0] cfg_data = '0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = '0;
    logic [7:0] s_frame_x_offset = '0, s_frame_y_offset = '0;
    logic [7:0] s_pixel_x = '0, s_pixel_y = '0;
    logic [7:0] s_src_red = '0, s_src_green = '0, s_src_blue = '0, s_src_alpha = '0;
    logic       s_blend_enable = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_out_red, m_out_green, m_out_blue, m_out_alpha;
    logic       m_in_canvas;
    int         fail_count, pending_count;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;
    bit         hold_off = 1'b0;

    always #4 aclk = ~aclk;

    animated_frame_canvas_compositor u_dut (.*);

    tb_canvas_checker u_checker (.*);

    // Timeout guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic int clamp_small(input int v);
        if (v < 1) return 1;
        if (v > 20) return 20;
        return v;
    endfunction

    task automatic write_reg(input logic idx, input logic [8:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one request and wait for it to be taken; valid drops only when idling.
    task automatic send_request(input logic [1:0] op, input logic [7:0] xo, yo, px, py,
                                input logic [31:0] rgba, input logic blend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_frame_x_offset <= xo;
        s_frame_y_offset <= yo;
        s_pixel_x        <= px;
        s_pixel_y        <= py;
        {s_src_alpha, s_src_blue, s_src_green, s_src_red} <= rgba;
        s_blend_enable   <= blend;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // Random request aimed mostly at the small canvas region in use.
    task automatic random_request(input int w, input int h);
        logic [1:0] op;
        logic [7:0] xo, yo, px, py, a;
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) op = OP_COMPOSITE;
        else if (pick < 70) op = OP_CLEAR;
        else if (pick < 95) op = OP_READ;
        else op = OP_UNUSED;
        if ($urandom_range(9) < 8) begin
            xo = 8'($urandom_range(w / 2));
            yo = 8'($urandom_range(h / 2));
            px = 8'($urandom_range(w));
            py = 8'($urandom_range(h));
        end else begin
            {xo, yo, px, py} = $urandom;
        end
        pick = $urandom_range(9);
        a = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom);
        send_request(op, xo, yo, px, py, {a, 24'($urandom)}, $urandom_range(3) != 0);
    endtask

    initial begin
        int sizes[5][2] = '{'{256, 256}, '{16, 12}, '{1, 1}, '{0, 300}, '{200, 7}};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: field extremes, each operation, clipping and blend corners.
        write_reg(REG_WIDTH, 9'd8);
        write_reg(REG_HEIGHT, 9'd6);
        send_request(OP_COMPOSITE, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_READ, 0, 0, 0, 5, 0, 1'b0);
        send_request(OP_COMPOSITE, 0, 0, 0, 0, 32'h80_40C0_20, 1'b1);
        send_request(OP_COMPOSITE, 0, 0, 0, 0, 32'h00_1234_56, 1'b1);
        send_request(OP_COMPOSITE, 0, 0, 0, 0, 32'h01_FFFF_FF, 1'b1);
        send_request(OP_COMPOSITE, 2, 1, 3, 2, 32'h7F_0102_03, 1'b1);
        send_request(OP_COMPOSITE, 2, 1, 3, 2, 32'hFE_FFFF_FF, 1'b1);
        send_request(OP_COMPOSITE, 7, 5, 0, 0, 32'hFF_0000_FF, 1'b1);
        send_request(OP_COMPOSITE, 8, 0, 0, 0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_COMPOSITE, 0, 6, 0, 0, 32'hFFFF_FFFF, 1'b0);
        send_request(OP_COMPOSITE, 255, 255, 255, 255, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_READ, 255, 255, 7, 0, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_READ, 0, 0, 8, 0, 0, 1'b0);
        send_request(OP_READ, 0, 0, 255, 255, 0, 1'b0);
        send_request(OP_UNUSED, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b1);
        send_request(OP_READ, 0, 0, 0, 5, 0, 1'b0);
        drain();

        // Random phases over several canvas sizes and idling mixes.
        for (int phase = 0; phase < 5; phase++) begin
            write_reg(REG_WIDTH, 9'(sizes[phase][0]));
            write_reg(REG_HEIGHT, 9'(sizes[phase][1]));
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            if (phase == 4) begin
                // Long receiver hold-off while requests keep coming.
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 210; n++)
                random_request(clamp_small(sizes[phase][0]), clamp_small(sizes[phase][1]));
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### animated_frame_canvas_compositor.f
hw/rtl/afcc_pkg.sv
hw/rtl/afcc_ram.sv
hw/rtl/afcc_div.sv
hw/rtl/afcc_front.sv
hw/rtl/afcc_back.sv
hw/rtl/animated_frame_canvas_compositor.sv
tb/tb_canvas_checker.sv
tb/tb.sv
